// File: rtl/tpdq_pkg.sv
// Shared constants, codes and types of the timed packet delay queue.
`default_nettype none
package tpdq_pkg;

	localparam int SLOTS       = 16;
	localparam int SLOT_BYTES  = 64;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int PTR_W       = SLOT_W + 1;
	localparam int BYTE_W      = $clog2(SLOT_BYTES);
	localparam int STORE_AW    = SLOT_W + BYTE_W;
	localparam int SIZE_W      = 7;
	localparam int DATA_W      = 8;
	localparam int TIME_W      = 32;
	localparam int LAG_W       = 24;
	localparam int ADDR_W      = 32;
	localparam int PORT_W      = 16;
	localparam int KIND_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [LAG_W-1:0]  LAG_RESET    = LAG_W'(200);
	localparam logic [APB_AW-1:0] REG_LAG_ADDR = APB_AW'(0);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_STATUS = 2'd0,
		KIND_BYTE   = 2'd1,
		KIND_NONE   = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_TRUNC = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_META   = 3'b010,
		S_STREAM = 3'b100
	} fsm_t;

	typedef struct packed {
		logic [TIME_W-1:0] release_time;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] address;
		logic [PORT_W-1:0] port;
	} slot_meta_t;

endpackage
`default_nettype wire

// File: rtl/tpdq_byte_ram.sv
// Simple dual-port byte RAM with one write port and one registered read port.
`default_nettype none
module tpdq_byte_ram #(
	parameter int AW = 10,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/timed_packet_delay_queue.sv
// Top level of the timed packet delay queue: ring of packet slots with timed release.
`default_nettype none
// The queue holds up to SLOTS packets of at most SLOT_BYTES bytes each and lets a
// packet leave only once the tick count has reached its release time, which is the
// tick count at its last pushed byte plus lag_ticks (compared wrap-safe). A push
// beat carries one byte and is done in the cycle it is taken, so bytes may arrive
// back to back; the last byte of a packet yields one status result in the next
// cycle. A pop beat reads the head slot's descriptor at the accepting edge and
// judges it in the cycle after, with busy high; a packet that is not due, or an
// empty ring, yields one "nothing ready" result in the cycle after that.
// Otherwise the packet streams out one byte per cycle, and busy stays high after
// the beat through the descriptor judgement and then through the reading of each
// byte through the single read port of the packet byte memory. The receiver
// cannot stall: every result is shown for exactly one cycle with result_strobe
// high and must be taken then. A packet pushed while the ring is full is refused
// whole, and bytes beyond the slot size are dropped with the packet flagged as
// truncated. lag_ticks is written over the APB port at address 0 and should only
// change while the block is idle.
module timed_packet_delay_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	// Command channel.
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [tpdq_pkg::DATA_W-1:0]   data_byte,
	input  logic                          last_byte,
	input  logic [tpdq_pkg::ADDR_W-1:0]   dest_address,
	input  logic [tpdq_pkg::PORT_W-1:0]   dest_port,
	input  logic [tpdq_pkg::TIME_W-1:0]   now_time,
	// Result channel.
	output logic                          result_strobe,
	output logic [tpdq_pkg::KIND_W-1:0]   kind,
	output logic [tpdq_pkg::STATUS_W-1:0] push_status,
	output logic [tpdq_pkg::DATA_W-1:0]   out_byte,
	output logic                          out_last,
	output logic [tpdq_pkg::SIZE_W-1:0]   out_size,
	output logic [tpdq_pkg::ADDR_W-1:0]   out_address,
	output logic [tpdq_pkg::PORT_W-1:0]   out_port,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpdq_pkg::APB_AW-1:0]   paddr,
	input  logic [tpdq_pkg::APB_DW-1:0]   pwdata,
	output logic [tpdq_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	import tpdq_pkg::*;

	// Control state.
	fsm_t              state_q;
	fsm_t              state_next;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [SIZE_W-1:0] fill_q;
	logic              refused_q;
	logic              trunc_q;
	logic [LAG_W-1:0]  lag_q;
	logic [SIZE_W-1:0] idx_q;

	// Pop pipeline.
	logic [TIME_W-1:0] now_s1;
	slot_meta_t        meta_rd_q;

	// Slot descriptor memory, written at the tail and read at the head.
	slot_meta_t        meta_mem [SLOTS];
	slot_meta_t        meta_wr;

	// Result registers.
	logic              strobe_q;
	kind_t             kind_q;
	status_t           status_q;
	logic              last_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PORT_W-1:0] port_q;
	logic [DATA_W-1:0] store_rdata;

	logic              accept;
	logic              push_acc;
	logic              pop_acc;
	logic [PTR_W-1:0]  occupancy;
	logic              ring_full;
	logic              ring_empty;
	logic              pkt_start;
	logic              refused_n;
	logic              trunc_n;
	logic              has_room;
	logic              store_we;
	logic [SIZE_W-1:0] fill_n;
	logic              commit;
	logic              status_beat;
	status_t           push_code;
	logic [TIME_W-1:0] due_diff;
	logic              head_due;
	logic              release_ok;
	logic              skip_empty;
	logic              in_meta;
	logic              in_stream;
	logic              last_beat;
	logic              cfg_write;
	logic [STORE_AW-1:0] store_waddr;
	logic [STORE_AW-1:0] store_raddr;

	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;
	assign push_acc = accept & (operation == OP_PUSH);
	assign pop_acc  = accept & (operation == OP_POP);

	// Pointers count modulo twice the slot count, so full and empty differ.
	assign occupancy  = tail_q - head_q;
	assign ring_full  = (occupancy >= PTR_W'(SLOTS));
	assign ring_empty = (tail_q == head_q);

	// Push path. The full check is made once, at the first byte of a packet; the
	// refused and truncated flags then ride along until the last byte.
	assign pkt_start = (fill_q == '0) & ~refused_q & ~trunc_q;
	assign refused_n = refused_q | (pkt_start & ring_full);
	assign has_room  = (fill_q < SIZE_W'(SLOT_BYTES));
	assign store_we  = push_acc & ~refused_n & has_room;
	assign trunc_n   = trunc_q | (~refused_n & ~has_room);
	assign fill_n    = store_we ? (fill_q + SIZE_W'(1)) : fill_q;
	assign commit    = push_acc & last_byte & ~refused_n;
	assign status_beat = push_acc & last_byte;
	assign push_code = refused_n ? ST_FULL : (trunc_n ? ST_TRUNC : ST_OK);
	assign store_waddr = {tail_q[SLOT_W-1:0], fill_q[BYTE_W-1:0]};

	always_comb begin
		meta_wr.release_time = now_time + TIME_W'(lag_q);
		meta_wr.size         = fill_n;
		meta_wr.address      = dest_address;
		meta_wr.port         = dest_port;
	end

	// Pop path. The descriptor read on the pop beat is judged in the next cycle.
	assign in_meta    = (state_q == S_META);
	assign in_stream  = (state_q == S_STREAM);
	assign due_diff   = now_s1 - meta_rd_q.release_time;
	assign head_due   = ~due_diff[TIME_W-1];
	assign release_ok = ~ring_empty & head_due & (meta_rd_q.size != '0);
	// A due slot with no stored bytes is dropped with a "nothing ready" answer.
	assign skip_empty = ~ring_empty & head_due & (meta_rd_q.size == '0);
	assign last_beat  = ((idx_q + SIZE_W'(1)) == meta_rd_q.size);
	assign store_raddr = {head_q[SLOT_W-1:0], idx_q[BYTE_W-1:0]};

	always_ff @(posedge clk) begin
		if (commit) begin
			meta_mem[tail_q[SLOT_W-1:0]] <= meta_wr;
		end
		if (pop_acc) begin
			meta_rd_q <= meta_mem[head_q[SLOT_W-1:0]];
			now_s1    <= now_time;
		end
	end

	tpdq_byte_ram #(
		.AW (STORE_AW),
		.DW (DATA_W)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (data_byte),
		.re    (in_stream),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	// Sequencer: idle, judge the head descriptor, then stream its bytes.
	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (pop_acc) state_next = S_META;
			end
			S_META: begin
				state_next = release_ok ? S_STREAM : S_IDLE;
			end
			S_STREAM: begin
				if (last_beat) state_next = S_IDLE;
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			refused_q <= 1'b0;
			trunc_q   <= 1'b0;
			idx_q     <= '0;
			strobe_q  <= 1'b0;
		end else begin
			state_q  <= state_next;
			strobe_q <= status_beat | (in_meta & ~release_ok) | in_stream;
			if (push_acc) begin
				if (last_byte) begin
					fill_q    <= '0;
					refused_q <= 1'b0;
					trunc_q   <= 1'b0;
				end else begin
					fill_q    <= fill_n;
					refused_q <= refused_n;
					trunc_q   <= trunc_n;
				end
			end
			if (commit) begin
				tail_q <= tail_q + PTR_W'(1);
			end
			if ((in_meta & skip_empty) | (in_stream & last_beat)) begin
				head_q <= head_q + PTR_W'(1);
			end
			if (in_meta) begin
				idx_q <= '0;
			end else if (in_stream) begin
				idx_q <= idx_q + SIZE_W'(1);
			end
		end
	end

	// Result payload; the byte itself comes straight from the memory read register.
	always_ff @(posedge clk) begin
		if (status_beat) begin
			kind_q   <= KIND_STATUS;
			status_q <= push_code;
			last_q   <= 1'b1;
			size_q   <= '0;
			addr_q   <= '0;
			port_q   <= '0;
		end else if (in_meta) begin
			kind_q   <= KIND_NONE;
			status_q <= ST_OK;
			last_q   <= 1'b1;
			size_q   <= '0;
			addr_q   <= '0;
			port_q   <= '0;
		end else if (in_stream) begin
			kind_q   <= KIND_BYTE;
			status_q <= ST_OK;
			last_q   <= last_beat;
			size_q   <= meta_rd_q.size;
			addr_q   <= meta_rd_q.address;
			port_q   <= meta_rd_q.port;
		end
	end

	assign result_strobe = strobe_q;
	assign kind          = kind_q;
	assign push_status   = status_q;
	assign out_byte      = (kind_q == KIND_BYTE) ? store_rdata : '0;
	assign out_last      = last_q;
	assign out_size      = size_q;
	assign out_address   = addr_q;
	assign out_port      = port_q;

	// Configuration register.
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready & (paddr == REG_LAG_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q <= LAG_RESET;
		end else if (cfg_write) begin
			lag_q <= pwdata[LAG_W-1:0];
		end
	end

	assign prdata = (paddr == REG_LAG_ADDR) ? APB_DW'(lag_q) : '0;

endmodule
`default_nettype wire
